>>> sv/sha256_pkg.sv
package sha256_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned NUM_H    = 8;
   localparam int unsigned WIN_LEN  = 16;
   localparam int unsigned NUM_RND  = 64;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_APPEND     = 2'd0;
   localparam logic [1:0] REQ_APPEND_FIN = 2'd1;
   localparam logic [1:0] REQ_FINISH     = 2'd2;

   localparam logic [31:0] INIT_H [NUM_H] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [NUM_RND] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef logic [31:0] word_type;
   typedef word_type [NUM_H-1:0] hash_type;

   // commands from the sequencer to the compression core
   typedef struct packed {
      logic       load_byte;
      logic [7:0] byte_val;
      logic       start;
      logic       reinit;
   } core_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   function automatic word_type rotr(input word_type v, input int unsigned n);
      rotr = (v >> n) | (v << (WORD_W - n));
   endfunction

   function automatic word_type big_sig0(input word_type v);
      big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic word_type big_sig1(input word_type v);
      big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic word_type small_sig0(input word_type v);
      small_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type v);
      small_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

endpackage

>>> sv/sha256_compress.sv
module sha256_compress
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  core_ctrl_type ctrl,
   output core_stat_type stat,
   output hash_type      hash_words
);

   word_type       h_ff   [NUM_H];
   word_type       h_in   [NUM_H];
   word_type       v_ff   [NUM_H];
   word_type       v_in   [NUM_H];
   word_type       win_ff [WIN_LEN];
   word_type       win_in [WIN_LEN];
   logic [5:0]     rnd_ff, rnd_in;
   logic           busy_ff, busy_in;
   logic           add_ff, add_in;

   word_type       t1, t2, w_new, ch, maj;
   logic [WIN_LEN*WORD_W-1:0] win_flat;

   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         win_flat[(WIN_LEN-1-i)*WORD_W +: WORD_W] = win_ff[i];
      end
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1    = v_ff[7] + big_sig1(v_ff[4]) + ch + ROUND_K[rnd_ff] + win_ff[0];
      t2    = big_sig0(v_ff[0]) + maj;
      w_new = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];
   end

   always_comb begin
      h_in    = h_ff;
      v_in    = v_ff;
      win_in  = win_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      add_in  = 1'b0;
      if (busy_ff) begin
         // one round a cycle, schedule window slides along
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WIN_LEN-1] = w_new;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         rnd_in  = rnd_ff + 6'd1;
         if (rnd_ff == 6'(NUM_RND - 1)) begin
            busy_in = 1'b0;
            add_in  = 1'b1;
         end
      end else if (add_ff) begin
         for (int i = 0; i < NUM_H; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end else if (ctrl.start) begin
         v_in    = h_ff;
         rnd_in  = '0;
         busy_in = 1'b1;
      end else if (ctrl.load_byte) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[i] = win_flat[(WIN_LEN-1-i)*WORD_W - 8 +: WORD_W];
         end
         win_in[WIN_LEN-1] = {win_ff[WIN_LEN-1][23:0], ctrl.byte_val};
      end else if (ctrl.reinit) begin
         h_in = INIT_H;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff    <= INIT_H;
         busy_ff <= 1'b0;
         add_ff  <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         h_ff    <= h_in;
         busy_ff <= busy_in;
         add_ff  <= add_in;
         rnd_ff  <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      win_ff <= win_in;
   end

   always_comb begin
      for (int i = 0; i < NUM_H; i++) begin
         hash_words[i] = h_ff[i];
      end
      stat.busy = busy_ff | add_ff;
      stat.done = add_ff;
   end

endmodule

>>> sv/sha256_byte_stream_hasher_unit.sv
// sha-256 over a byte stream
// req channel: one transfer per message byte. req_tuser selects append,
// append then finish, or finish without a byte (code 3 is dropped).
// req_tdata carries the byte.
// rsp channel: after a finish, eight transfers carry the digest words,
// word 0 first, with the word position on rsp_tuser and tlast on word 7.
// a byte that does not fill the block leaves req_tready high for the next
// byte. the byte that completes a 64-byte block starts the round unit,
// which runs the rounds and then the chaining add before the unit resumes.
// a finish feeds pad bytes one per cycle, except while a block compresses,
// and runs one or two compressions, then presents the eight words; a single
// shared round datapath serves every block.
// req_tready is low while a block is compressing, during padding and while
// digest words are being presented. if the receiver stalls, the current
// word simply holds until it is taken.
// reset: synchronous, restores the initial hash values, clears the byte
// count and the partial block count.
module sha256_byte_stream_hasher_unit
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WAIT = 5'b00010,
      S_PAD  = 5'b00100,
      S_OUT  = 5'b01000,
      S_RSV  = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [5:0]    fill_ff, fill_in;        // bytes held in the current block
   logic [60:0]   msg_ff, msg_in;          // message byte count, wraps
   logic          pad_ff, pad_in;          // a finish is in progress
   logic          pad_first_ff, pad_first_in;
   logic          pad_len_ff, pad_len_in;  // length field being written
   logic [2:0]    out_idx_ff, out_idx_in;
   logic          start_ff, start_in;

   core_ctrl_type ctrl;
   core_ctrl_type ctrl_q;
   core_stat_type cstat;
   hash_type      hash_words;

   logic          req_xfer, rsp_xfer;
   logic          put;
   logic [7:0]    put_val;
   logic [63:0]   bit_len;
   logic [2:0]    len_sel;

   sha256_compress u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_q),
      .stat       (cstat),
      .hash_words (hash_words)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_xfer   = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = hash_words[out_idx_ff];
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == 3'd7);

   // bit length, big-endian, byte picked by position within the length field
   assign bit_len = {msg_ff, 3'b000};
   assign len_sel = 3'd7 - fill_ff[2:0];

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      msg_in       = msg_ff;
      pad_in       = pad_ff;
      pad_first_in = pad_first_ff;
      pad_len_in   = pad_len_ff;
      out_idx_in   = out_idx_ff;
      put          = 1'b0;
      put_val      = req_tdata;
      ctrl         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  REQ_APPEND: begin
                     put    = 1'b1;
                     msg_in = msg_ff + 61'd1;
                  end
                  REQ_APPEND_FIN: begin
                     put          = 1'b1;
                     msg_in       = msg_ff + 61'd1;
                     pad_in       = 1'b1;
                     pad_first_in = 1'b1;
                     pad_len_in   = 1'b0;
                     state_in     = S_PAD;
                  end
                  REQ_FINISH: begin
                     pad_in       = 1'b1;
                     pad_first_in = 1'b1;
                     pad_len_in   = 1'b0;
                     state_in     = S_PAD;
                  end
                  default: begin
                     // unused code, dropped
                  end
               endcase
            end
         end
         S_PAD: begin
            put          = 1'b1;
            pad_first_in = 1'b0;
            if (pad_first_ff) begin
               put_val = PAD_BYTE;
            end else if (!pad_len_ff && fill_ff != LEN_OFFSET) begin
               put_val = 8'h00;
            end else begin
               put_val    = bit_len[{len_sel, 3'b000} +: 8];
               pad_len_in = 1'b1;
            end
         end
         S_WAIT: begin
            if (cstat.done) begin
               if (!pad_ff) begin
                  state_in = S_IDLE;
               end else if (pad_len_ff) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_PAD;
               end
            end
         end
         S_OUT: begin
            if (rsp_xfer) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  // back to the initial values for the next message
                  ctrl.reinit = 1'b1;
                  msg_in      = '0;
                  fill_in     = '0;
                  pad_in      = 1'b0;
                  pad_len_in  = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // byte into the block; the 64th byte kicks off a compression
      if (put) begin
         ctrl.load_byte = 1'b1;
         ctrl.byte_val  = put_val;
         fill_in        = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            state_in = S_WAIT;
         end
      end
   end

   // start is issued the cycle after the last byte lands in the window
   assign start_in = put && (fill_ff == 6'd63);

   always_comb begin
      ctrl_q       = ctrl;
      ctrl_q.start = start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         msg_ff       <= '0;
         pad_ff       <= 1'b0;
         pad_first_ff <= 1'b0;
         pad_len_ff   <= 1'b0;
         out_idx_ff   <= '0;
         start_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         msg_ff       <= msg_in;
         pad_ff       <= pad_in;
         pad_first_ff <= pad_first_in;
         pad_len_ff   <= pad_len_in;
         out_idx_ff   <= out_idx_in;
         start_ff     <= start_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result channel open together");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cstat.done |-> (state_ff == S_WAIT))
      else $error("compression finished outside of wait");

   a_wait_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && !start_ff) |-> cstat.busy)
      else $error("waiting with no compression running");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> (state_ff == S_IDLE && fill_ff == 6'd0 && msg_ff == 61'd0))
      else $error("state not cleared after digest");
`endif

endmodule
